// ===== sv/sst_pkg.sv =====
`default_nettype none

package sst_pkg;

   // Slot count of the queue; it holds one fewer entry, QUEUE_CAP.
   localparam int QUEUE_SLOTS = 8;
   localparam int QUEUE_CAP   = QUEUE_SLOTS - 1;
   // Count holds 0..QUEUE_CAP.
   localparam int COUNT_W     = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] arrived;
      logic [3:0]  need;
   } sst_entry_type;

   typedef struct packed {
      logic shift;   // queue pops: take the neighbor's entry
      logic load;    // this cell is where the arriving entry lands
   } sst_cell_ctl_type;

endpackage

`default_nettype wire

// ===== sv/single_server_fifo_service_tracker.sv =====
`default_nettype none

// Single-server FIFO service tracker. Every accepted req word is one tick of
// a single-server queue: an optional arrival with its service need, then one
// server step. Each arrival takes the next 16-bit id, dropped or not. Waiting
// entries live in a row of sst_cell registers, the head in cell 0; a start of
// service shifts the whole row one cell toward the head in the same cycle, and
// the arrival is written straight into the first free cell, so no ring
// pointers are kept. An arrival that finds an empty queue and an idle server
// starts at once with a wait of zero. The queue holds QUEUE_SLOTS-1 entries.
// Rate: one word per clock cycle while req_stall is low; the whole tick
// (push, pop, shift, wait add) resolves combinationally and lands in the
// rsp output register. A new req word is taken while the previous rsp word
// is still pending as long as rsp_stall is low; req_stall is high only
// while a finished rsp word is held by rsp_stall. The wait total is a
// 32-bit saturating sum; waits and ids wrap at 65536. No clearing pass
// follows reset: cell contents are only read once written.
module single_server_fifo_service_tracker
   import sst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_arrives,
   input  wire logic [3:0]  req_service_need,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   output logic             rsp_dropped,
   output logic [15:0]      rsp_assigned_id,
   output logic             rsp_started,
   output logic [15:0]      rsp_started_id,
   output logic [15:0]      rsp_started_wait,
   output logic [2:0]       rsp_queue_count,
   output logic [31:0]      rsp_wait_accum,
   output logic [15:0]      rsp_total_arrivals
);

   // ---- tracker state ----
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [3:0]         remain_ff, remain_in;
   logic [15:0]        tick_ff;
   logic [15:0]        next_id_ff, next_id_in;
   logic [31:0]        wait_sum_ff, wait_sum_in;

   // ---- output word register ----
   logic        rsp_valid_ff;
   logic        accepted_ff, dropped_ff, started_ff;
   logic [15:0] assigned_ff, started_id_ff, started_wait_ff;
   logic [2:0]  queue_count_ff;
   logic [31:0] wait_accum_ff;
   logic [15:0] total_arrivals_ff;

   // ---- tick decode ----
   logic               take;
   logic               full, enq, drop, busy, from_store, pop, pop_store, push;
   logic [3:0]         need_fix;
   logic [COUNT_W-1:0] load_pos;
   logic [15:0]        wait_ticks;
   logic [32:0]        sum_wide;
   sst_entry_type      new_entry, head;

   sst_entry_type      entries [QUEUE_CAP];
   sst_cell_ctl_type   cell_ctl [QUEUE_CAP];

   // Hold the input only while a finished word waits downstream.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      full       = (count_ff == COUNT_W'(QUEUE_CAP));
      enq        = req_arrives & ~full;
      drop       = req_arrives & full;
      // a need of zero behaves as one tick
      need_fix   = (req_service_need == 4'd0) ? 4'd1 : req_service_need;
      new_entry  = '{id: next_id_ff, arrived: tick_ff, need: need_fix};
      busy       = (remain_ff != 4'd0);
      from_store = (count_ff != '0);
      pop        = ~busy & (from_store | enq);
      pop_store  = pop & from_store;
      // arrival stays in the row unless it goes straight to the server
      push       = enq & ~(pop & ~from_store);
      // empty queue: this tick's arrival goes straight to the server
      head       = from_store ? entries[0] : new_entry;
      wait_ticks = tick_ff - head.arrived;
      sum_wide   = {1'b0, wait_sum_ff} + {17'd0, wait_ticks};
      // row shifts toward the head on a pop, so the free cell moves down one
      load_pos   = pop_store ? (count_ff - COUNT_W'(1)) : count_ff;

      unique case ({push, pop_store})
         2'b10:   count_in = count_ff + COUNT_W'(1);
         2'b01:   count_in = count_ff - COUNT_W'(1);
         default: count_in = count_ff;
      endcase

      priority if (busy) begin
         remain_in = remain_ff - 4'd1;
      end else if (pop) begin
         remain_in = head.need - 4'd1;
      end else begin
         remain_in = remain_ff;
      end

      wait_sum_in = pop ? (sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0]) : wait_sum_ff;
      next_id_in  = req_arrives ? (next_id_ff + 16'd1) : next_id_ff;
   end

   // ---- cell row ----
   for (genvar k = 0; k < QUEUE_CAP; k++) begin : g_cell
      sst_entry_type nbr;

      if (k < QUEUE_CAP - 1) begin : g_mid
         assign nbr = entries[k+1];
      end else begin : g_last
         assign nbr = entries[k];
      end

      assign cell_ctl[k].shift = take & pop_store;
      assign cell_ctl[k].load  = take & push & (load_pos == COUNT_W'(k));

      sst_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[k]),
         .shift_data (nbr),
         .load_data  (new_entry),
         .entry      (entries[k])
      );
   end

   // ---- state and output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         remain_ff    <= '0;
         tick_ff      <= '0;
         next_id_ff   <= '0;
         wait_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            count_ff     <= count_in;
            remain_ff    <= remain_in;
            tick_ff      <= tick_ff + 16'd1;
            next_id_ff   <= next_id_in;
            wait_sum_ff  <= wait_sum_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         accepted_ff       <= enq;
         dropped_ff        <= drop;
         assigned_ff       <= req_arrives ? next_id_ff : 16'd0;
         started_ff        <= pop;
         started_id_ff     <= pop ? head.id : 16'd0;
         started_wait_ff   <= pop ? wait_ticks : 16'd0;
         queue_count_ff    <= 3'(count_in);
         wait_accum_ff     <= wait_sum_in;
         total_arrivals_ff <= next_id_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = accepted_ff;
   assign rsp_dropped        = dropped_ff;
   assign rsp_assigned_id    = assigned_ff;
   assign rsp_started        = started_ff;
   assign rsp_started_id     = started_id_ff;
   assign rsp_started_wait   = started_wait_ff;
   assign rsp_queue_count    = queue_count_ff;
   assign rsp_wait_accum     = wait_accum_ff;
   assign rsp_total_arrivals = total_arrivals_ff;

   // ---- checks ----
   // occupancy never passes the usable depth
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_CAP))
      else $error("queue count above capacity");

   // a word taken while the server is busy never reports a start
   a_busy_no_start: assert property (@(posedge clock) disable iff (reset)
      (take && busy) |=> !rsp_started)
      else $error("service started while server busy");

   // a word is never both enqueued and dropped
   a_acc_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_dropped))
      else $error("arrival both accepted and dropped");

   // queue state freezes while the output word is held
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> ($stable(count_ff) && $stable(tick_ff)))
      else $error("state moved while output held");

endmodule

`default_nettype wire

// ===== sv/sst_cell.sv =====
`default_nettype none

module sst_cell
   import sst_pkg::*;
(
   input  wire logic             clock,
   input  wire sst_cell_ctl_type ctl,
   input  wire sst_entry_type    shift_data,
   input  wire sst_entry_type    load_data,
   output sst_entry_type         entry
);

   sst_entry_type entry_ff;

   always_ff @(posedge clock) begin
      priority if (ctl.load) begin
         entry_ff <= load_data;
      end else if (ctl.shift) begin
         entry_ff <= shift_data;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== sim/single_server_fifo_service_tracker_test.sv =====
module single_server_fifo_service_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sst_pkg::*;

   // One response word per request word; every field is compared.
   typedef struct packed {
      logic               accepted;
      logic               dropped;
      logic [15:0]        assigned_id;
      logic               started;
      logic [15:0]        started_id;
      logic [15:0]        started_wait;
      logic [2:0]         queue_count;
      logic [31:0]        wait_accum;
      logic [15:0]        total_arrivals;
   } tick_outcome_type;

   // Opening rows: pinned rows carry their outcome typed in, the rest go
   // through the queue model.
   typedef struct packed {
      logic             arrives;
      logic [3:0]       need;
      logic             pinned;
      tick_outcome_type want;
   } plan_row_type;

   localparam int OPENING_ROWS = 22;
   localparam int RANDOM_TICKS = 1950;
   localparam int CALM_TICKS   = 250;   // tail of the run with no idling at all

   localparam plan_row_type OPENING_PLAN [OPENING_ROWS] = '{
      // idle tick right after reset; the need field is ignored
      '{1'b0, 4'hF, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 16'd0, 3'd0, 32'd0, 16'd0}},
      // empty queue, idle server: the arrival starts on its own tick, wait 0
      '{1'b1, 4'h1, 1'b1, '{1'b1, 1'b0, 16'd0, 1'b1, 16'd0, 16'd0, 3'd0, 32'd0, 16'd1}},
      // zero need runs as a need of one, so the server is free again next tick
      '{1'b1, 4'h0, 1'b1, '{1'b1, 1'b0, 16'd1, 1'b1, 16'd1, 16'd0, 3'd0, 32'd0, 16'd2}},
      // longest service: keeps the server busy while the queue fills
      '{1'b1, 4'hF, 1'b1, '{1'b1, 1'b0, 16'd2, 1'b1, 16'd2, 16'd0, 3'd0, 32'd0, 16'd3}},
      '{1'b1, 4'h1, 1'b0, '0},
      '{1'b1, 4'h3, 1'b0, '0},
      '{1'b1, 4'h7, 1'b0, '0},
      '{1'b1, 4'h8, 1'b0, '0},
      '{1'b1, 4'hF, 1'b0, '0},
      '{1'b1, 4'h2, 1'b0, '0},
      '{1'b1, 4'h0, 1'b0, '0},
      // queue full: turned away, id still used up
      '{1'b1, 4'hA, 1'b1, '{1'b0, 1'b1, 16'd10, 1'b0, 16'd0, 16'd0, 3'd7, 32'd0, 16'd11}},
      '{1'b1, 4'h5, 1'b0, '0},
      // idle ticks run the server down, then the head starts after a long wait
      '{1'b0, 4'hA, 1'b0, '0},
      '{1'b0, 4'h5, 1'b0, '0},
      '{1'b0, 4'h0, 1'b0, '0},
      '{1'b0, 4'hF, 1'b0, '0},
      '{1'b0, 4'h6, 1'b0, '0},
      '{1'b0, 4'h9, 1'b0, '0},
      '{1'b1, 4'hC, 1'b0, '0},
      '{1'b1, 4'h4, 1'b0, '0},
      '{1'b0, 4'h0, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   logic              req_valid;
   logic              req_stall;
   logic              req_arrives;
   logic [3:0]        req_service_need;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_accepted;
   logic              rsp_dropped;
   logic [15:0]       rsp_assigned_id;
   logic              rsp_started;
   logic [15:0]       rsp_started_id;
   logic [15:0]       rsp_started_wait;
   logic [2:0]        rsp_queue_count;
   logic [31:0]       rsp_wait_accum;
   logic [15:0]       rsp_total_arrivals;

   // Queue model state: head of the line at index 0.
   sst_entry_type     waiting [$];
   logic [3:0]        busy_left  = '0;
   logic [15:0]       now_tick   = '0;
   logic [15:0]       id_next    = '0;
   logic [31:0]       wait_total = '0;

   tick_outcome_type  outcomes_due [$];
   tick_outcome_type  row_want;
   logic              row_pinned;
   int unsigned       ticks_taken = 0;
   int unsigned       mismatches  = 0;
   bit                calm_tail   = 1'b0;

   single_server_fifo_service_tracker DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_arrives        (req_arrives),
      .req_service_need   (req_service_need),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_dropped        (rsp_dropped),
      .rsp_assigned_id    (rsp_assigned_id),
      .rsp_started        (rsp_started),
      .rsp_started_id     (rsp_started_id),
      .rsp_started_wait   (rsp_started_wait),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_wait_accum     (rsp_wait_accum),
      .rsp_total_arrivals (rsp_total_arrivals)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One tick of the single-server queue: push the arrival (or drop it),
   // then either count down the service in progress or start the head.
   function automatic tick_outcome_type serve_tick(logic arrives, logic [3:0] need);
      tick_outcome_type outcome;
      sst_entry_type    head;
      logic [32:0]      sum;
      outcome = '0;
      if (arrives) begin
         outcome.assigned_id = id_next;
         if (waiting.size() == QUEUE_CAP) begin
            outcome.dropped = 1'b1;
         end else begin
            head.id      = id_next;
            head.arrived = now_tick;
            head.need    = (need == 4'd0) ? 4'd1 : need;
            waiting.push_back(head);
            outcome.accepted = 1'b1;
         end
         id_next = id_next + 16'd1;
      end
      if (busy_left != 4'd0) begin
         busy_left = busy_left - 4'd1;
      end else if (waiting.size() != 0) begin
         head = waiting.pop_front();
         busy_left = head.need - 4'd1;
         outcome.started      = 1'b1;
         outcome.started_id   = head.id;
         outcome.started_wait = now_tick - head.arrived;
         // saturate instead of wrapping
         sum = {1'b0, wait_total} + {17'd0, outcome.started_wait};
         wait_total = sum[32] ? '1 : sum[31:0];
      end
      outcome.queue_count    = 3'(waiting.size());
      outcome.wait_accum     = wait_total;
      outcome.total_arrivals = id_next;
      now_tick = now_tick + 16'd1;
      return outcome;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0d, got %0d", field, want, seen);
         mismatches++;
      end
   endtask

   // Both handshakes are looked at here, on the rising edge, before the
   // block's registers move. The response side goes first so the queue of
   // pending outcomes never sees a push and pop out of order.
   always @(posedge clock) begin
      tick_outcome_type seen;
      tick_outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_accepted, rsp_dropped, rsp_assigned_id, rsp_started,
                     rsp_started_id, rsp_started_wait, rsp_queue_count,
                     rsp_wait_accum, rsp_total_arrivals};
            if (outcomes_due.size() == 0) begin
               $error("response word with no request word pending");
               mismatches++;
            end else begin
               want = outcomes_due.pop_front();
               check_field("accepted",       32'(want.accepted),       32'(seen.accepted));
               check_field("dropped",        32'(want.dropped),        32'(seen.dropped));
               check_field("assigned_id",    32'(want.assigned_id),    32'(seen.assigned_id));
               check_field("started",        32'(want.started),        32'(seen.started));
               check_field("started_id",     32'(want.started_id),     32'(seen.started_id));
               check_field("started_wait",   32'(want.started_wait),   32'(seen.started_wait));
               check_field("queue_count",    32'(want.queue_count),    32'(seen.queue_count));
               check_field("wait_accum",     want.wait_accum,          seen.wait_accum);
               check_field("total_arrivals", 32'(want.total_arrivals), 32'(seen.total_arrivals));
            end
         end
         if (req_valid && !req_stall) begin
            // the model always runs so its state tracks every tick
            want = serve_tick(req_arrives, req_service_need);
            outcomes_due.push_back(row_pinned ? row_want : want);
            ticks_taken++;
         end
      end
   end

   // Present one request word at the falling edge and hold it until taken.
   task automatic offer_tick(input logic arrives, input logic [3:0] need,
                             input logic pinned, input tick_outcome_type want);
      int unsigned goal;
      goal = ticks_taken + 1;
      req_valid        <= 1'b1;
      req_arrives      <= arrives;
      req_service_need <= need;
      row_pinned       <= pinned;
      row_want         <= want;
      do @(negedge clock); while (ticks_taken != goal);
   endtask

   // Sender holds off until every pending response word has come back.
   task automatic drain_queue();
      req_valid <= 1'b0;
      do @(negedge clock); while (outcomes_due.size() != 0);
   endtask

   // Response-side stall: random bursts, none in the calm tail.
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (!calm_tail && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   initial begin
      int          row;
      int          items_left;
      int          stretch;
      int          k;
      int unsigned arrive_pct;
      bit          gappy;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_arrives      = 1'b0;
      req_service_need = 4'd0;
      row_pinned       = 1'b0;
      row_want         = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed opening: reset values, fill to full, drops, zero need,
      // long waits after the server runs down
      for (row = 0; row < OPENING_ROWS; row++) begin
         if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         offer_tick(OPENING_PLAN[row].arrives, OPENING_PLAN[row].need,
                    OPENING_PLAN[row].pinned, OPENING_PLAN[row].want);
      end
      drain_queue();

      // random ticks in stretches of one arrival rate each: sparse traffic
      // keeps the server idle, heavy traffic with long needs fills the queue
      items_left = RANDOM_TICKS;
      while (items_left > 0) begin
         stretch = $urandom_range(20, 80);
         if (stretch > items_left) stretch = items_left;
         case ($urandom_range(0, 3))
            0: arrive_pct = 10;
            1: arrive_pct = 35;
            2: arrive_pct = 60;
            default: arrive_pct = 90;
         endcase
         gappy = $urandom_range(0, 2) != 0;
         for (k = 0; k < stretch; k++) begin
            calm_tail = items_left <= CALM_TICKS;
            if (!calm_tail && gappy && $urandom_range(0, 7) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 19)) @(negedge clock);
            end
            offer_tick($urandom_range(1, 100) <= arrive_pct,
                       4'($urandom_range(0, 15)), 1'b0, '0);
            items_left--;
         end
         if (!calm_tail && $urandom_range(0, 5) == 0) drain_queue();
      end

      req_valid <= 1'b0;
      while (outcomes_due.size() != 0) @(negedge clock);
      // catch any stray response word after the last expected one
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hang guard, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
